// ===== hw/rtl/wcss_pkg.sv =====
// ----------------------------------------------------------------------------
// wcss_pkg
// Shared constants, register indexes and types for the wall column span setup.
// ----------------------------------------------------------------------------
package wcss_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CAMERA_DISTANCE = 2'd0;
    localparam logic [1:0] CFG_VERTICAL_OFFSET = 2'd1;
    localparam logic [1:0] CFG_LIGHT_GAIN      = 2'd2;

    localparam logic [15:0] CAMERA_DISTANCE_RST = 16'd4096;
    localparam logic [7:0]  VERTICAL_OFFSET_RST = 8'd0;
    localparam logic [15:0] LIGHT_GAIN_RST      = 16'd256;

    localparam logic [21:0] STEP_MAX  = 22'h3F_FFFF;
    localparam logic [16:0] LIGHT_ONE = 17'h1_0000;

    // texture edge in texels; the Q6.16 row wrap is tied to 64
    localparam int TEX_SIZE = 64;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 120;

    // per-item data that rides along beside the dividers
    typedef struct packed {
        logic [8:0]  column;
        logic [15:0] depth;
        logic [10:0] tcol;
        logic        diag;
        logic        vneg;   // vertical offset is negative
        logic        lsat;   // light saturates at 1.0
    } t_side;

    // integer square root, elaboration use only
    function automatic int isqrt(input int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) begin
            r = r + 1;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/wcss_div.sv =====
// ----------------------------------------------------------------------------
// wcss_div
// Pipelined restoring divider, one quotient bit per stage, Q_W stages.
// Requires i_num < i_den * 2**Q_W.
// ----------------------------------------------------------------------------
module wcss_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 16,
    parameter int Q_W   = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_rem_nz
);

    localparam int EXT_W = Q_W + DEN_W;

    logic [EXT_W-1:0] w_ext;
    logic [DEN_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_low [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];

    assign w_ext = EXT_W'(i_num);

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DEN_W-1:0] w_prem;
        logic [Q_W-1:0]   w_plow;
        logic [Q_W-1:0]   w_pquo;
        logic [DEN_W-1:0] w_pden;
        logic [DEN_W:0]   w_trial;
        logic [DEN_W:0]   w_diff;
        logic             w_bit;

        if (k == 0) begin : g_first
            assign w_prem = w_ext[EXT_W-1:Q_W];
            assign w_plow = w_ext[Q_W-1:0];
            assign w_pquo = '0;
            assign w_pden = i_den;
        end else begin : g_next
            assign w_prem = r_rem[k-1];
            assign w_plow = r_low[k-1];
            assign w_pquo = r_quo[k-1];
            assign w_pden = r_den[k-1];
        end

        always_comb begin
            w_trial = {w_prem, w_plow[Q_W-1]};
            w_diff  = w_trial - {1'b0, w_pden};
            w_bit   = (w_trial >= {1'b0, w_pden});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_bit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_low[k] <= w_plow << 1;
                r_quo[k] <= {w_pquo[Q_W-2:0], w_bit};
                r_den[k] <= w_pden;
            end
        end
    end

    assign o_quo    = r_quo[Q_W-1];
    assign o_rem_nz = |r_rem[Q_W-1];

endmodule

// ===== hw/rtl/wall_column_span_setup.sv =====
// ----------------------------------------------------------------------------
// wall_column_span_setup
// Per-column wall span set-up for a raycaster: rows, texture coordinates,
// light factor and depth from one ray hit.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one ray per transfer; tuser carries the hit flag.
//   A ray without a hit is consumed and gives no result. Each hit gives one
//   transfer on the master stream.
//   Configuration is a plain write port (camera distance, vertical offset,
//   light gain); write only while no column is in flight.
//   Throughput: one column per cycle, sustained while the master stream is not stalled.
//   The 32-stage dividers for height, head offset and light are followed by
//   the texture step divider, which needs the line height.
//   The whole pipeline advances together; when the receiver holds tready
//   low with a result waiting, every stage holds and the slave tready drops,
//   so nothing is lost or repeated. Bubbles move up while the output is free.
//   Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module wall_column_span_setup #(
    parameter int SCREEN_ROWS = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // column[8:0] corrected_distance[24:9] raw_distance[40:25]
    // hit_frac_x[56:41] hit_frac_y[72:57] vertical_side[73]
    // ray_x_positive[74] ray_y_negative[75] diagonal_wall[76]
    // texture_index[80:77] zero[87:81]
    input  logic [wcss_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // hit[0]
    input  logic        i_s_axis_tuser,
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_column[8:0] start_row[16:9] end_row[24:17] texel_column[35:25]
    // texel_row_base[42:36] texel_row_start[64:43] texel_row_step[86:65]
    // light_level[103:87] depth_write[119:104]
    output logic [wcss_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int TEX_SIZE = wcss_pkg::TEX_SIZE;
    localparam int ROW_W   = $clog2(SCREEN_ROWS + 1);
    localparam int HN_W    = 16 + ROW_W;
    localparam int H_W     = HN_W - 4;
    localparam int SW      = H_W + 3;
    localparam int DIV_LAT = 32;
    localparam int SQW     = $clog2(TEX_SIZE) + 17;
    localparam int WD      = wcss_pkg::isqrt(2 * TEX_SIZE * TEX_SIZE);
    localparam int W_W     = $clog2(WD + 2);
    localparam int TP_W    = 16 + W_W;

    typedef struct packed {
        wcss_pkg::t_side  p;
        logic [H_W-1:0]   h;
        logic signed [32:0] hq;
        logic [16:0]      lum;
    } t_mid;

    // configuration registers
    logic [15:0]       r_cam;
    logic signed [7:0] r_voff;
    logic [15:0]       r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam  <= wcss_pkg::CAMERA_DISTANCE_RST;
            r_voff <= wcss_pkg::VERTICAL_OFFSET_RST;
            r_gain <= wcss_pkg::LIGHT_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                wcss_pkg::CFG_CAMERA_DISTANCE: r_cam  <= i_cfg_wdata;
                wcss_pkg::CFG_VERTICAL_OFFSET: r_voff <= i_cfg_wdata[7:0];
                wcss_pkg::CFG_LIGHT_GAIN:      r_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_o_valid;

    assign w_en            = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---------------- stage A: capture
    logic        r_a_valid;
    logic [8:0]  r_a_col;
    logic [15:0] r_a_d, r_a_raw, r_a_frac;
    logic        r_a_vside, r_a_xpos, r_a_yneg, r_a_diag;
    logic [3:0]  r_a_tid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_axis_tvalid && i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_col   <= i_s_axis_tdata[8:0];
            r_a_d     <= (i_s_axis_tdata[24:9] == 16'd0) ? 16'd1 : i_s_axis_tdata[24:9];
            r_a_raw   <= i_s_axis_tdata[40:25];
            r_a_frac  <= i_s_axis_tdata[73] ? i_s_axis_tdata[56:41] : i_s_axis_tdata[72:57];
            r_a_vside <= i_s_axis_tdata[73];
            r_a_xpos  <= i_s_axis_tdata[74];
            r_a_yneg  <= i_s_axis_tdata[75];
            r_a_diag  <= i_s_axis_tdata[76];
            r_a_tid   <= i_s_axis_tdata[80:77];
        end
    end

    // ---------------- stage B: products
    logic            r_b_valid;
    logic [8:0]      r_b_col;
    logic [15:0]     r_b_d, r_b_raw;
    logic            r_b_mirror, r_b_diag;
    logic [3:0]      r_b_tid;
    logic [TP_W-1:0] r_b_tprod;
    logic [31:0]     r_b_dsq;
    logic [H_W-1:0]  r_b_hn;
    logic [W_W-1:0]  w_a_wide;
    logic [HN_W-1:0] w_a_hrows;

    assign w_a_wide  = r_a_diag ? W_W'(WD) : W_W'(TEX_SIZE);
    assign w_a_hrows = HN_W'(SCREEN_ROWS) * HN_W'(r_cam);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_col    <= r_a_col;
            r_b_d      <= r_a_d;
            r_b_raw    <= r_a_raw;
            r_b_mirror <= (!r_a_vside && r_a_xpos) || (r_a_vside && r_a_yneg);
            r_b_diag   <= r_a_diag;
            r_b_tid    <= r_a_tid;
            r_b_tprod  <= TP_W'(r_a_frac) * TP_W'(w_a_wide);
            r_b_dsq    <= 32'(r_a_d) * 32'(r_a_d);
            r_b_hn     <= w_a_hrows[HN_W-1:4];
        end
    end

    // ---------------- stage C: texture column, light saturation, divider set-up
    logic                 r_c_valid;
    wcss_pkg::t_side      r_c_p;
    logic [15:0]          r_c_d;
    logic [31:0]          r_c_dsq;
    logic [H_W-1:0]       r_c_hn;
    logic [39:0]          r_c_lnum;
    logic [31:0]          r_c_hqnum;
    logic [W_W-1:0]       w_b_wide, w_b_c, w_b_cm;
    logic [47:0]          w_b_lim, w_b_lnum;
    logic                 w_b_sat;
    logic [7:0]           w_b_mag;
    wcss_pkg::t_side      w_b_p;

    always_comb begin
        w_b_wide = r_b_diag ? W_W'(WD) : W_W'(TEX_SIZE);
        w_b_c    = r_b_tprod[TP_W-1:16];
        w_b_cm   = r_b_mirror ? (w_b_wide - w_b_c - W_W'(1)) : w_b_c;
        w_b_lnum = {8'd0, r_gain, 24'd0};
        w_b_lim  = {r_b_dsq, 16'd0} + 48'(r_b_dsq);
        w_b_sat  = (w_b_lnum >= w_b_lim);
        w_b_mag  = r_voff[7] ? 8'(-r_voff) : 8'(r_voff);
        w_b_p.column = r_b_col;
        w_b_p.depth  = r_b_raw;
        w_b_p.tcol   = 11'(w_b_cm) + 11'(16'(w_b_wide + W_W'(1)) * 16'(r_b_tid));
        w_b_p.diag   = r_b_diag;
        w_b_p.vneg   = r_voff[7];
        w_b_p.lsat   = w_b_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_p     <= w_b_p;
            r_c_d     <= r_b_d;
            r_c_dsq   <= r_b_dsq;
            r_c_hn    <= r_b_hn;
            r_c_lnum  <= w_b_sat ? 40'd0 : w_b_lnum[39:0];
            r_c_hqnum <= {w_b_mag, 24'd0};
        end
    end

    // ---------------- dividers: height, head offset, light
    logic [DIV_LAT-1:0] w_q_h, w_q_hq, w_q_l;
    logic               w_hq_nz, w_h_nz, w_l_nz;

    wcss_div #(.NUM_W(H_W), .DEN_W(16), .Q_W(DIV_LAT)) u_div_h (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_c_hn), .i_den(r_c_d),
        .o_quo(w_q_h), .o_rem_nz(w_h_nz)
    );

    wcss_div #(.NUM_W(32), .DEN_W(16), .Q_W(DIV_LAT)) u_div_hq (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_c_hqnum), .i_den(r_c_d),
        .o_quo(w_q_hq), .o_rem_nz(w_hq_nz)
    );

    wcss_div #(.NUM_W(40), .DEN_W(32), .Q_W(DIV_LAT)) u_div_l (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_c_lnum), .i_den(r_c_dsq),
        .o_quo(w_q_l), .o_rem_nz(w_l_nz)
    );

    logic            r_d1_v [DIV_LAT];
    wcss_pkg::t_side r_d1_p [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_d1_v[k] <= 1'b0;
        end else if (w_en) begin
            r_d1_v[0] <= r_c_valid;
            for (int k = 1; k < DIV_LAT; k++) r_d1_v[k] <= r_d1_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_p[0] <= r_c_p;
            for (int k = 1; k < DIV_LAT; k++) r_d1_p[k] <= r_d1_p[k-1];
        end
    end

    // ---------------- stage E: height, head offset in Q.16, light
    logic           r_e_valid;
    t_mid           r_e_m;
    logic [H_W-1:0] r_e_hc;
    t_mid           w_d_m;
    logic [32:0]    w_d_qu;

    always_comb begin
        w_d_qu    = 33'(w_q_hq) + 33'(w_hq_nz);
        w_d_m.p   = r_d1_p[DIV_LAT-1];
        w_d_m.h   = w_q_h[H_W-1:0];
        w_d_m.hq  = w_d_m.p.vneg ? -$signed(w_d_qu) : $signed(33'(w_q_hq));
        w_d_m.lum = w_d_m.p.lsat ? wcss_pkg::LIGHT_ONE : w_q_l[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= r_d1_v[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_m  <= w_d_m;
            r_e_hc <= (w_d_m.h == '0) ? H_W'(1) : w_d_m.h;
        end
    end

    // ---------------- texture step divider
    logic [SQW-1:0] w_q_s;
    logic           w_s_nz;

    wcss_div #(.NUM_W(SQW), .DEN_W(H_W), .Q_W(SQW)) u_div_s (
        .i_clk(i_clk), .i_en(w_en), .i_num(SQW'(TEX_SIZE) << 16), .i_den(r_e_hc),
        .o_quo(w_q_s), .o_rem_nz(w_s_nz)
    );

    logic r_d2_v [SQW];
    t_mid r_d2_m [SQW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQW; k++) r_d2_v[k] <= 1'b0;
        end else if (w_en) begin
            r_d2_v[0] <= r_e_valid;
            for (int k = 1; k < SQW; k++) r_d2_v[k] <= r_d2_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_m[0] <= r_e_m;
            for (int k = 1; k < SQW; k++) r_d2_m[k] <= r_d2_m[k-1];
        end
    end

    // ---------------- stage G: clipped span, step saturation
    logic               r_g_valid;
    wcss_pkg::t_side    r_g_p;
    logic [ROW_W-1:0]   r_g_top, r_g_bot;
    logic [21:0]        r_g_a, r_g_rate;
    logic signed [32:0] r_g_hq;
    logic [16:0]        r_g_lum;
    t_mid               w_f_m;
    logic signed [SW-1:0] w_f_half, w_f_head, w_f_ctr, w_f_top, w_f_bot, w_f_max;
    logic signed [SW-1:0] w_f_ct, w_f_cb;

    always_comb begin
        w_f_m    = r_d2_m[SQW-1];
        w_f_half = $signed(SW'(w_f_m.h >> 1));
        w_f_head = SW'(w_f_m.hq >>> 16);
        w_f_ctr  = $signed(SW'(SCREEN_ROWS / 2));
        w_f_max  = $signed(SW'(SCREEN_ROWS));
        w_f_top  = w_f_ctr - w_f_half + w_f_head;
        w_f_bot  = w_f_ctr + w_f_half + w_f_head;
        priority if (w_f_top < 0)       w_f_ct = '0;
        else if (w_f_top > w_f_max)     w_f_ct = w_f_max;
        else                            w_f_ct = w_f_top;
        priority if (w_f_bot < 0)       w_f_cb = '0;
        else if (w_f_bot > w_f_max)     w_f_cb = w_f_max;
        else                            w_f_cb = w_f_bot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (w_en) begin
            r_g_valid <= r_d2_v[SQW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_p    <= w_f_m.p;
            r_g_top  <= ROW_W'(w_f_ct);
            r_g_bot  <= ROW_W'(w_f_cb);
            r_g_a    <= 22'(w_f_ct - w_f_ctr + w_f_half);
            r_g_rate <= (32'(w_q_s) > 32'(wcss_pkg::STEP_MAX)) ?
                        wcss_pkg::STEP_MAX : 22'(w_q_s);
            r_g_hq   <= w_f_m.hq;
            r_g_lum  <= w_f_m.lum;
        end
    end

    // ---------------- stage M: texture row products
    logic             r_m_valid;
    wcss_pkg::t_side  r_m_p;
    logic [ROW_W-1:0] r_m_top, r_m_bot;
    logic [21:0]      r_m_rate, r_m_p1;
    logic [37:0]      r_m_p2;
    logic [16:0]      r_m_lum;
    logic [43:0]      w_g_p1;
    logic signed [55:0] w_g_p2;

    assign w_g_p1 = 44'(r_g_a) * 44'(r_g_rate);
    assign w_g_p2 = r_g_hq * $signed({1'b0, r_g_rate});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_p    <= r_g_p;
            r_m_top  <= r_g_top;
            r_m_bot  <= r_g_bot;
            r_m_rate <= r_g_rate;
            r_m_lum  <= r_g_lum;
            r_m_p1   <= w_g_p1[21:0];
            r_m_p2   <= w_g_p2[37:0];
        end
    end

    // ---------------- stage O: output register
    logic [8:0]  r_o_col;
    logic [7:0]  r_o_start, r_o_end;
    logic [10:0] r_o_tcol;
    logic [6:0]  r_o_base;
    logic [21:0] r_o_rstart, r_o_step;
    logic [16:0] r_o_lum;
    logic [15:0] r_o_depth;
    logic [37:0] w_m_pos;

    assign w_m_pos = {r_m_p1, 16'd0} - r_m_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_col    <= r_m_p.column;
            r_o_start  <= 8'(r_m_top);
            r_o_end    <= 8'(r_m_bot);
            r_o_tcol   <= r_m_p.tcol;
            r_o_base   <= r_m_p.diag ? 7'(TEX_SIZE + 1) : 7'd0;
            r_o_rstart <= w_m_pos[37:16];
            r_o_step   <= r_m_rate;
            r_o_lum    <= r_m_lum;
            r_o_depth  <= r_m_p.depth;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_depth, r_o_lum, r_o_step, r_o_rstart, r_o_base,
                              r_o_tcol, r_o_end, r_o_start, r_o_col};

    // ---------------- assertions
    a_light_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_lum <= wcss_pkg::LIGHT_ONE))
        else $error("light level above 1.0");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_top <= r_m_bot))
        else $error("span start after span end");

    a_span_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g_valid |-> (32'(r_g_bot) <= 32'(SCREEN_ROWS)))
        else $error("span end beyond screen");

    a_row_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_base == 7'd0 || r_o_base == 7'(TEX_SIZE + 1)))
        else $error("bad texel row base");

    a_light_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d1_v[DIV_LAT-1] && !r_d1_p[DIV_LAT-1].lsat) |-> (w_q_l <= 32'h1_0000))
        else $error("light quotient out of range");

endmodule
